// File: design/pcxrle_pkg.sv
package pcxrle_pkg;

    // Widths of the configuration, the pixel counter and the run count.
    localparam int DIM_W = 17;
    localparam int PIX_W = 33;
    localparam int RUN_W = 6;
    localparam int CFG_INDEX_W = 2;

    // Palette geometry.
    localparam int PALETTE_ENTRIES = 256;
    localparam int COLOR_W = 24;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_TRANSPARENCY = 2'd2;

    // Input selector codes.
    localparam logic FUNC_PALETTE = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Byte values.
    localparam logic [7:0] RUN_MARK = 8'd192;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR = 8'd0;
    localparam logic [DIM_W-1:0] DIM_MAX = 17'd65536;

    // A dimension of zero counts as one, anything above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: design/pcxrle_ram.sv
module pcxrle_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/pcx_rle_palette_decoder.sv
// The first pixel of a run passes the palette read, the setup compare against the image
// size and the output register. Palette writes and run count bytes are taken one per cycle;
// no beat is taken while a run is in progress (palette read, run setup, then one pixel per
// cycle while the output is not stalled), and a zero run emits no pixel.
// Reset clears the pixel counter, the pending count and the transparency state and sets a
// 1 by 1 image without transparency; the palette holds no defined value until it is written.
module pcx_rle_palette_decoder
    import pcxrle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [39:0]            s_tdata,  // data_byte, entry_index, entry_red, entry_green, entry_blue
    input  logic                   s_tuser,  // func
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,  // red, green, blue, alpha
    output logic                   m_tlast,  // run_end
    output logic [1:0]             m_tuser,  // image_end, run_clipped
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic               use_t_reg, use_t_next;
    logic [PIX_W-1:0]   total_reg, total_next;
    logic [PIX_W-1:0]   pw_reg, pw_next;
    logic               pend_reg, pend_next;
    logic [RUN_W-1:0]   pend_len_reg, pend_len_next;
    logic [7:0]         ti_reg, ti_next;
    logic               tv_reg, tv_next;
    logic [RUN_W-1:0]   left_reg, left_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload held for the run in progress.
    logic [7:0]         idx_reg;
    logic [RUN_W-1:0]   cnt_reg;
    logic [COLOR_W-1:0] rgb_reg;
    logic [7:0]         alpha_reg;
    logic               clip_reg;
    logic [31:0]        m_tdata_reg;
    logic               m_tlast_reg;
    logic [1:0]         m_tuser_reg;

    logic [7:0]         in_byte;
    logic               in_accept;
    logic               start_run;
    logic               out_load;
    logic [COLOR_W-1:0] pal_rdata;
    logic [2*DIM_W-1:0] area;

    // Setup and emit values.
    logic [PIX_W-1:0]   pw_base;
    logic               tv_base;
    logic               latch_t;
    logic [7:0]         ti_setup;
    logic               tv_setup;
    logic [PIX_W-1:0]   remaining;
    logic               clip_setup;
    logic [RUN_W-1:0]   n_setup;
    logic [PIX_W-1:0]   pw_inc;
    logic               last_pix;
    logic               img_end;

    assign in_byte = s_tdata[7:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign start_run = in_accept && (s_tuser == FUNC_DATA) && (pend_reg || (in_byte < RUN_MARK));
    assign cfg_ready = 1'b1;
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tuser = m_tuser_reg;

    // Palette memory: written by palette beats, read by the index of a run.
    pcxrle_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .clk  (clk),
        .we   (in_accept && (s_tuser == FUNC_PALETTE)),
        .waddr(s_tdata[15:8]),
        .wdata(s_tdata[39:16]),
        .re   (start_run),
        .raddr(in_byte),
        .rdata(pal_rdata)
    );

    // Image size, recomputed every cycle from the clamped dimensions.
    assign area = clamp_dim(width_reg) * clamp_dim(height_reg);
    assign total_next = area[PIX_W-1:0];

    // Run setup: wrap a stale counter, latch the transparent index, clip the run.
    always_comb
    begin
        pw_base = (pw_reg >= total_reg) ? '0 : pw_reg;
        tv_base = (pw_reg >= total_reg) ? 1'b0 : tv_reg;
        latch_t = use_t_reg && (pw_base == '0) && !tv_base;
        ti_setup = latch_t ? idx_reg : ti_reg;
        tv_setup = latch_t || tv_base;
        remaining = total_reg - pw_base;
        clip_setup = {{(PIX_W-RUN_W){1'b0}}, cnt_reg} > remaining;
        n_setup = clip_setup ? remaining[RUN_W-1:0] : cnt_reg;
    end

    // Per-pixel counter values.
    assign pw_inc = pw_reg + {{(PIX_W-1){1'b0}}, 1'b1};
    assign last_pix = (left_reg == {{(RUN_W-1){1'b0}}, 1'b1});
    assign img_end = (pw_inc == total_reg);

    // Next-state logic of the control registers.
    always_comb
    begin
        state_next = state_reg;
        width_next = width_reg;
        height_next = height_reg;
        use_t_next = use_t_reg;
        pw_next = pw_reg;
        pend_next = pend_reg;
        pend_len_next = pend_len_reg;
        ti_next = ti_reg;
        tv_next = tv_reg;
        left_next = left_reg;
        m_tvalid_next = m_tvalid_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:      width_next = cfg_data;
                REG_IMAGE_HEIGHT:     height_next = cfg_data;
                REG_USE_TRANSPARENCY: use_t_next = cfg_data[0];
                default:              ;
            endcase
        end

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == FUNC_DATA))
                begin
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        pend_len_next = '0;
                        state_next = ST_SETUP;
                    end
                    else if (in_byte >= RUN_MARK)
                    begin
                        pend_next = 1'b1;
                        pend_len_next = in_byte[RUN_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                pw_next = pw_base;
                ti_next = ti_setup;
                tv_next = tv_setup;
                left_next = n_setup;
                state_next = (n_setup == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    left_next = left_reg - {{(RUN_W-1){1'b0}}, 1'b1};
                    if (img_end)
                    begin
                        pw_next = '0;
                        tv_next = 1'b0;
                    end
                    else
                    begin
                        pw_next = pw_inc;
                    end
                    if (last_pix)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            width_reg <= {{(DIM_W-1){1'b0}}, 1'b1};
            height_reg <= {{(DIM_W-1){1'b0}}, 1'b1};
            use_t_reg <= 1'b0;
            total_reg <= {{(PIX_W-1){1'b0}}, 1'b1};
            pw_reg <= '0;
            pend_reg <= 1'b0;
            pend_len_reg <= '0;
            ti_reg <= '0;
            tv_reg <= 1'b0;
            left_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            width_reg <= width_next;
            height_reg <= height_next;
            use_t_reg <= use_t_next;
            total_reg <= total_next;
            pw_reg <= pw_next;
            pend_reg <= pend_next;
            pend_len_reg <= pend_len_next;
            ti_reg <= ti_next;
            tv_reg <= tv_next;
            left_reg <= left_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers: run parameters, palette color and the output beat.
    // The palette word holds red in its low byte and blue in its high byte.
    always_ff @(posedge clk)
    begin
        if (start_run)
        begin
            idx_reg <= in_byte;
            cnt_reg <= pend_reg ? pend_len_reg : {{(RUN_W-1){1'b0}}, 1'b1};
        end
        if (state_reg == ST_SETUP)
        begin
            rgb_reg <= pal_rdata;
            alpha_reg <= (tv_setup && (ti_setup == idx_reg)) ? ALPHA_CLEAR : ALPHA_OPAQUE;
            clip_reg <= clip_setup;
        end
        if (out_load)
        begin
            m_tdata_reg <= {alpha_reg, rgb_reg[23:16], rgb_reg[15:8], rgb_reg[7:0]};
            m_tlast_reg <= last_pix;
            m_tuser_reg <= {last_pix && clip_reg, img_end};
        end
    end

    // A run beat always moves on to the setup cycle.
    a_run_setup: assert property (@(posedge clk) disable iff (!rst_n)
        start_run |=> (state_reg == ST_SETUP))
        else $error("run beat did not enter setup");

    // While pixels are emitted some remain to be sent.
    a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (left_reg != '0))
        else $error("emit state with no pixels left");

    // The final pixel of an image restarts the counter.
    a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && img_end) |=> (pw_reg == '0) && !tv_reg)
        else $error("counter did not wrap at image end");

endmodule

// File: verif/tb_pcx_rle_palette_decoder.sv
module tb_pcx_rle_palette_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import pcxrle_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_COUNT = 8;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic       func;
        logic [7:0] data_byte;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
    } stream_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       run_end;
        logic       image_end;
        logic       run_clipped;
    } pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [39:0]            s_tdata = '0;  // data_byte, entry_index, entry_red, entry_green, entry_blue
    logic                   s_tuser = 1'b0;  // func
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;  // red, green, blue, alpha
    logic                   m_tlast;  // run_end
    logic [1:0]             m_tuser;  // image_end, run_clipped
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;

    // Stimulus and scoreboard storage.
    stream_item_t stream_items[$];
    stream_item_t offer_item;
    pixel_t       expected_pixels[$];
    bit           loaded[PALETTE_ENTRIES];

    // Mirror of the decoder state and its registers.
    logic [COLOR_W-1:0] palette_copy[PALETTE_ENTRIES];
    logic [DIM_W-1:0]   width_reg = 17'd1;
    logic [DIM_W-1:0]   height_reg = 17'd1;
    logic               transp_reg = 1'b0;
    longint unsigned    pix_done = 0;
    logic               count_armed = 1'b0;
    logic [RUN_W-1:0]   armed_len = '0;
    logic [7:0]         key_index = '0;
    logic               key_valid = 1'b0;

    // Handshake bookkeeping between the clock edges.
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int tx_gap = 0;
    int rx_wait = 0;
    int cycle_count = 0;
    int error_count = 0;

    pcx_rle_palette_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // A zero dimension counts as one, anything above the maximum as the maximum.
    function automatic longint unsigned fit_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > DIM_MAX)
        begin
            return longint'(DIM_MAX);
        end
        return longint'(v);
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("%s", msg);
        end
    endfunction

    // Works out the pixels that one accepted input beat produces.
    function automatic void decode_beat(input stream_item_t it);
        logic [7:0]       idx;
        logic [RUN_W:0]   len;
        longint unsigned  total;
        longint unsigned  remaining;
        logic             cut;
        int               n;
        int               k;
        logic [COLOR_W-1:0] rgb;
        pixel_t           px;
        if (it.func == FUNC_PALETTE)
        begin
            palette_copy[it.entry_index] = {it.entry_red, it.entry_green, it.entry_blue};
            return;
        end
        if (count_armed)
        begin
            len = {1'b0, armed_len};
            idx = it.data_byte;
            count_armed = 1'b0;
            armed_len = '0;
        end
        else if (it.data_byte >= RUN_MARK)
        begin
            count_armed = 1'b1;
            armed_len = RUN_W'(it.data_byte - RUN_MARK);
            return;
        end
        else
        begin
            len = 7'd1;
            idx = it.data_byte;
        end

        // A counter left beyond a shrunk image restarts as at an image end.
        total = fit_dim(width_reg) * fit_dim(height_reg);
        if (pix_done >= total)
        begin
            pix_done = 0;
            key_valid = 1'b0;
        end
        if (transp_reg && pix_done == 0 && !key_valid)
        begin
            key_index = idx;
            key_valid = 1'b1;
        end

        remaining = total - pix_done;
        cut = longint'(len) > remaining;
        n = cut ? int'(remaining) : int'(len);
        rgb = palette_copy[idx];
        for (k = 0; k < n; k++)
        begin
            pix_done++;
            px.red = rgb[23:16];
            px.green = rgb[15:8];
            px.blue = rgb[7:0];
            px.alpha = (key_valid && key_index == idx) ? ALPHA_CLEAR : ALPHA_OPAQUE;
            px.run_end = (k + 1 == n);
            px.image_end = (pix_done == total);
            px.run_clipped = (k + 1 == n) && cut;
            expected_pixels.push_back(px);
        end
        if (pix_done >= total)
        begin
            pix_done = 0;
            key_valid = 1'b0;
        end
    endfunction

    task automatic push_palette(input logic [7:0] idx, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b);
        stream_item_t it;
        it.func = FUNC_PALETTE;
        it.data_byte = 8'($urandom);
        it.entry_index = idx;
        it.entry_red = r;
        it.entry_green = g;
        it.entry_blue = b;
        loaded[idx] = 1'b1;
        stream_items.push_back(it);
    endtask

    task automatic push_data(input logic [7:0] value);
        stream_item_t it;
        it.func = FUNC_DATA;
        it.data_byte = value;
        it.entry_index = 8'($urandom);
        it.entry_red = 8'($urandom);
        it.entry_green = 8'($urandom);
        it.entry_blue = 8'($urandom);
        stream_items.push_back(it);
    endtask

    // Never look up a palette entry that was not written before.
    task automatic ensure_loaded(input logic [7:0] idx);
        if (!loaded[idx])
        begin
            push_palette(idx, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Mostly well-formed runs and literals, with some palette traffic and broken runs.
    task automatic queue_random(input int count);
        int         made;
        int         pick;
        int         run_len;
        logic [7:0] idx;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
            if (pick < 15)
            begin
                push_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                made += 1;
            end
            else if (pick < 60)
            begin
                idx = 8'($urandom_range(0, 255));
                ensure_loaded(idx);
                push_data(RUN_MARK + 8'(run_len));
                push_data(idx);
                made += 2;
            end
            else if (pick < 90)
            begin
                idx = 8'($urandom_range(0, 191));
                ensure_loaded(idx);
                push_data(idx);
                made += 1;
            end
            else
            begin
                // A palette write lands between the count byte and its index.
                idx = 8'($urandom_range(0, 255));
                ensure_loaded(idx);
                push_data(RUN_MARK + 8'(run_len));
                push_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                push_data(idx);
                made += 3;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH)
        begin
            width_reg = value;
        end
        else if (idx == REG_IMAGE_HEIGHT)
        begin
            height_reg = value;
        end
        else if (idx == REG_USE_TRANSPARENCY)
        begin
            transp_reg = value[0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every item is taken and every pixel has come, then lets the block settle.
    task automatic wait_for_idle();
        do
        begin
            @(negedge clk);
        end
        while (stream_items.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Input driver: offers the next item after its idle gap and holds it until taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_tvalid && !in_taken))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (stream_items.size() > 0)
                begin
                    offer_item = stream_items.pop_front();
                    s_tdata <= {offer_item.entry_blue, offer_item.entry_green,
                                offer_item.entry_red, offer_item.entry_index,
                                offer_item.data_byte};
                    s_tuser <= offer_item.func;
                    s_tvalid <= 1'b1;
                    tx_gap = tx_idle_en ? $urandom_range(0, 4) : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            in_taken = 1'b0;
        end
    end

    // Every accepted input beat feeds the predictor.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            in_taken = 1'b1;
            decode_beat(offer_item);
        end
    end

    // Long receiver hold-off, counted here in cycles.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
    end

    // Output ready: a random stall after each taken pixel, or the long hold.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                rx_wait = rx_idle_en ? $urandom_range(0, 4) : 0;
                out_taken = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Output monitor: each pixel beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            out_taken = 1'b1;
            got.red = m_tdata[7:0];
            got.green = m_tdata[15:8];
            got.blue = m_tdata[23:16];
            got.alpha = m_tdata[31:24];
            got.run_end = m_tlast;
            got.image_end = m_tuser[0];
            got.run_clipped = m_tuser[1];
            if (expected_pixels.size() == 0)
            begin
                flag_error($sformatf("unexpected pixel r=%h g=%h b=%h a=%h last=%b end=%b clip=%b",
                                     got.red, got.green, got.blue, got.alpha,
                                     got.run_end, got.image_end, got.run_clipped));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    flag_error($sformatf({"pixel mismatch: expected r=%h g=%h b=%h a=%h ",
                                          "last=%b end=%b clip=%b, got r=%h g=%h b=%h a=%h ",
                                          "last=%b end=%b clip=%b"},
                                         want.red, want.green, want.blue, want.alpha,
                                         want.run_end, want.image_end, want.run_clipped,
                                         got.red, got.green, got.blue, got.alpha,
                                         got.run_end, got.image_end, got.run_clipped));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [DIM_W-1:0] ph_width[PHASE_COUNT];
        logic [DIM_W-1:0] ph_height[PHASE_COUNT];
        logic             ph_transp[PHASE_COUNT];
        int               ph;
        ph_width = '{17'd5, 17'd0, 17'd16, 17'd65536, 17'd3, 17'd131071, 17'd1, 17'd9};
        ph_height = '{17'd3, 17'd7, 17'd4, 17'd65536, 17'd2, 17'd0, 17'd1, 17'd11};
        ph_transp = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on a 4 by 2 image with transparency.
        write_reg(REG_IMAGE_WIDTH, 17'd4);
        write_reg(REG_IMAGE_HEIGHT, 17'd2);
        write_reg(REG_USE_TRANSPARENCY, 17'd1);
        push_palette(8'd0, 8'hFF, 8'hFF, 8'hFF);
        push_palette(8'd255, 8'h00, 8'h00, 8'h00);
        push_palette(8'd191, 8'hA5, 8'h5A, 8'hC3);
        push_palette(8'd192, 8'h12, 8'h34, 8'h56);
        push_palette(8'd7, 8'h80, 8'h7F, 8'h01);
        // A zero-length run at pixel zero latches the transparent index.
        push_data(RUN_MARK);
        push_data(8'd7);
        // A second zero-length run must not replace it.
        push_data(RUN_MARK);
        push_data(8'd255);
        push_data(8'd7);
        push_data(8'd0);
        push_data(8'd191);
        // A palette write while a count is pending keeps the count.
        push_data(RUN_MARK + 8'd3);
        push_palette(8'd1, 8'h11, 8'h22, 8'h33);
        push_data(8'd192);
        // The longest run overruns the image end and is cut.
        push_data(8'd255);
        push_data(8'd255);
        // The next image latches a fresh transparent index.
        push_data(RUN_MARK + 8'd1);
        push_data(8'd0);
        push_data(8'd7);
        wait_for_idle();

        // Random phases over several image sizes, extremes and a shrink among them.
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_reg(REG_IMAGE_WIDTH, ph_width[ph]);
            write_reg(REG_IMAGE_HEIGHT, ph_height[ph]);
            write_reg(REG_USE_TRANSPARENCY, {16'd0, ph_transp[ph]});
            tx_idle_en = (ph % 3) != 1;
            rx_idle_en = (ph % 3) != 2;
            queue_random((ph == 3) ? 25 : 50);
            if (ph == 2)
            begin
                hold_request = 1'b1;
            end
            wait_for_idle();
        end

        if (expected_pixels.size() != 0)
        begin
            flag_error($sformatf("%0d pixels never arrived", expected_pixels.size()));
        end
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
